@@ hdl/crdw_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crdw_pkg
// Shared types and codes for the chunk reassembly dedup window block.
// ----------------------------------------------------------------------------
package crdw_pkg;

    // Records per origin; a power of two, since the slot is taken from the
    // low sequence number bits
    localparam int WINDOW = 16;

    typedef enum logic [2:0] {
        KIND_DROPPED  = 3'd0,
        KIND_PENDING  = 3'd1,
        KIND_RELEASED = 3'd2,
        KIND_OUT_WIN  = 3'd3,
        KIND_BAD      = 3'd4,
        KIND_FINAL    = 3'd5,
        KIND_UNKNOWN  = 3'd6
    } kind_t;

    localparam logic OP_CHUNK    = 1'b0;
    localparam logic OP_FINALIZE = 1'b1;

    typedef struct packed {
        logic        op;
        logic [1:0]  origin;
        logic [31:0] seq_num;
        logic [15:0] epoch;
        logic [7:0]  chunk_num;
        logic        is_last;
        logic [15:0] handle;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] out_handle;
        logic [31:0] low_watermark;
        logic        last;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_DECIDE,
        ST_ADVANCE,
        ST_EMIT,
        ST_RESULT
    } state_t;

endpackage

@@ hdl/chunk_reassembly_dedup_window_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chunk_reassembly_dedup_window_top
// Per-origin sequence reassembly with a low watermark and handle release.
// ----------------------------------------------------------------------------
// The block takes one transaction at a time; stall on the input is high until
// the last result of the previous transaction has been taken. A transaction
// with a single result passes through the idle state that accepts it, a read
// of the record from the slot memory, a decide step that writes it back where
// it changes, and a result state that presents it. A chunk that completes its
// record releases its n handles one at a time, each through a fetch, load and
// present sequence. A finalize walks the watermark with the single record
// read port, reading each record past the watermark in turn and stepping
// over every finalized one until it finds the end. A stalled output holds
// the block until its result is taken. The window depth is a package
// constant and must be a power of two.
module chunk_reassembly_dedup_window_top
    import crdw_pkg::*;
#(
    parameter int NUM_ORIGINS = 4,
    parameter int MAX_CHUNKS  = 8
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);
    localparam int OW    = (NUM_ORIGINS > 1) ? $clog2(NUM_ORIGINS) : 1;
    localparam int WW    = $clog2(WINDOW);
    localparam int NS    = NUM_ORIGINS * WINDOW;
    localparam int SW    = $clog2(NS);
    localparam int CW    = $clog2(MAX_CHUNKS + 1);
    localparam int HIW   = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int NH    = NS * MAX_CHUNKS;
    localparam int HW    = $clog2(NH);

    typedef struct packed {
        logic [31:0]         seq;
        logic [15:0]         epoch;
        logic                done;
        logic                fin;
        logic [7:0]          expected;
        logic [MAX_CHUNKS-1:0] map;
        logic [CW-1:0]       count;
    } rec_t;

    // Record and handle memories, valid bits in flops
    rec_t          rec_mem [NS];
    logic [15:0]   hnd_mem [NH];
    logic [NS-1:0] valid_reg, valid_next;
    logic [31:0]   wm_reg [NUM_ORIGINS];

    state_t    state_reg, state_next;
    in_item_t  item_reg;
    rec_t      rec_rd;
    rec_t      rec_wr;
    logic      rec_we;
    logic [SW-1:0] rd_addr, wr_addr, slot_reg;
    logic [15:0]   hnd_rd;
    logic          hnd_we;
    logic [HW-1:0] hnd_waddr, hnd_raddr;
    logic [CW-1:0] idx_reg, idx_next, n_reg, n_next;
    out_item_t     res_reg, res_next;
    logic          wm_we;
    logic [31:0]   wm_new;
    logic [31:0]   wm_cur, nxt_seq;
    logic [OW-1:0] org;
    logic          org_ok;
    logic          clr_valid, set_valid;
    logic [SW-1:0] adv_slot;
    logic          out_valid_q, fetch_reg;
    logic [CW-1:0] emit_idx_reg;
    logic          emit_last;

    assign org_ok = 32'(item_reg.origin) < 32'(NUM_ORIGINS);
    assign org    = OW'(item_reg.origin);
    assign wm_cur = org_ok ? wm_reg[org] : 32'd0;
    assign nxt_seq = wm_cur + 32'd1;
    assign slot_reg = SW'(32'(org) * 32'(WINDOW) + 32'(item_reg.seq_num[WW-1:0]));
    assign adv_slot = SW'(32'(org) * 32'(WINDOW) + 32'(nxt_seq[WW-1:0]));

    // Read record: item slot in READ, next watermark slot otherwise
    assign rd_addr   = (state_reg == ST_READ) ? slot_reg : adv_slot;
    assign hnd_raddr = HW'(32'(slot_reg) * 32'(MAX_CHUNKS) + 32'(idx_reg));

    always_ff @(posedge clk)
    begin
        rec_rd <= rec_mem[rd_addr];
        hnd_rd <= hnd_mem[hnd_raddr];
        if (rec_we)
        begin
            rec_mem[wr_addr] <= rec_wr;
        end
        if (hnd_we)
        begin
            hnd_mem[hnd_waddr] <= item_reg.handle;
        end
    end

    // Decide datapath
    logic          rec_hit, in_win, at_low, bad_cn;
    rec_t          r0, r1;
    logic [MAX_CHUNKS-1:0] bitm;
    logic          complete;

    assign in_win = {1'b0, item_reg.seq_num} <= {1'b0, wm_cur} + 33'(WINDOW);
    assign at_low = item_reg.seq_num <= wm_cur;
    assign rec_hit = valid_reg[slot_reg] && rec_rd.seq == item_reg.seq_num;
    assign bad_cn = item_reg.chunk_num == 8'd0 || 32'(item_reg.chunk_num) > 32'(MAX_CHUNKS);
    assign bitm = MAX_CHUNKS'(1) << (item_reg.chunk_num[HIW:0] - 1'b1);

    always_comb
    begin
        r0 = rec_rd;
        if (!rec_hit)
        begin
            r0 = '0;
            r0.seq = item_reg.seq_num;
            r0.epoch = item_reg.epoch;
        end
        r1 = r0;
        if (r0.epoch != item_reg.epoch)
        begin
            r1.count = '0;
            r1.expected = '0;
            r1.map = '0;
            r1.epoch = item_reg.epoch;
        end
        if (item_reg.is_last)
        begin
            r1.expected = item_reg.chunk_num;
        end
        hnd_waddr = HW'(32'(slot_reg) * 32'(MAX_CHUNKS) + 32'(r1.count));
        hnd_we = 1'b0;
        if ((r1.map & bitm) == '0 && 32'(r1.count) < 32'(MAX_CHUNKS))
        begin
            r1.map = r1.map | bitm;
            r1.count = r1.count + 1'b1;
            hnd_we = state_reg == ST_DECIDE && item_reg.op == OP_CHUNK && org_ok &&
                     in_win && !at_low && !bad_cn && !r0.done;
        end
        complete = r1.expected != 8'd0 && 32'(r1.count) == 32'(r1.expected);
        r1.done = complete;
    end

    // Next state and control
    always_comb
    begin
        state_next = state_reg;
        res_next = res_reg;
        idx_next = idx_reg;
        n_next = n_reg;
        rec_we = 1'b0;
        rec_wr = r1;
        wr_addr = slot_reg;
        wm_we = 1'b0;
        wm_new = nxt_seq;
        clr_valid = 1'b0;
        set_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                res_next = '{kind: KIND_PENDING, out_handle: 16'd0,
                             low_watermark: wm_cur, last: 1'b1};
                state_next = ST_RESULT;
                if (!org_ok)
                begin
                    res_next.kind = KIND_UNKNOWN;
                end
                else if (!in_win)
                begin
                    res_next.kind = KIND_OUT_WIN;
                end
                else if (item_reg.op == OP_FINALIZE)
                begin
                    if (at_low || !rec_hit)
                    begin
                        res_next.kind = KIND_UNKNOWN;
                    end
                    else
                    begin
                        rec_wr = rec_rd;
                        rec_wr.fin = 1'b1;
                        rec_wr.count = '0;
                        rec_we = 1'b1;
                        idx_next = '0;
                        state_next = ST_ADVANCE;
                    end
                end
                else if (at_low)
                begin
                    res_next.kind = KIND_DROPPED;
                end
                else if (bad_cn)
                begin
                    res_next.kind = KIND_BAD;
                end
                else if (r0.done)
                begin
                    res_next.kind = KIND_DROPPED;
                    rec_wr = r0;
                    rec_we = 1'b1;
                    set_valid = 1'b1;
                end
                else
                begin
                    rec_we = 1'b1;
                    set_valid = 1'b1;
                    if (complete)
                    begin
                        n_next = r1.count;
                        idx_next = '0;
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_ADVANCE:
            begin
                // rec_rd holds record at watermark + 1 once idx bit 0 is set (read in prior cycle)
                if (idx_reg[0] == 1'b0)
                begin
                    idx_next = idx_reg | CW'(1);
                end
                else if (valid_reg[adv_slot] && rec_rd.seq == nxt_seq && rec_rd.fin)
                begin
                    clr_valid = 1'b1;
                    wm_we = 1'b1;
                    idx_next = '0;
                end
                else
                begin
                    res_next = '{kind: KIND_FINAL, out_handle: 16'd0,
                                 low_watermark: wm_cur, last: 1'b1};
                    state_next = ST_RESULT;
                end
            end
            ST_EMIT:
            begin
                // hnd_rd valid in the cycle after idx set
                if (!out_valid_q || !out_stall)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_RESULT:
            begin
                if (!out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Emission pipeline: fetch stage then output register
    assign emit_last = emit_idx_reg + 1'b1 == n_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            valid_reg   <= '0;
            idx_reg     <= '0;
            n_reg       <= '0;
            out_valid_q <= 1'b0;
            fetch_reg   <= 1'b0;
            emit_idx_reg <= '0;
            for (int i = 0; i < NUM_ORIGINS; i++)
            begin
                wm_reg[i] <= '0;
            end
        end
        else
        begin
            valid_reg <= valid_next;
            n_reg <= n_next;
            if (wm_we)
            begin
                wm_reg[org] <= wm_new;
            end
            if (state_reg == ST_EMIT)
            begin
                // drain output, then fetch next handle
                if (out_valid_q && !out_stall)
                begin
                    out_valid_q <= 1'b0;
                    if (res_reg.last)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                else if (fetch_reg)
                begin
                    fetch_reg <= 1'b0;
                    out_valid_q <= 1'b1;
                    emit_idx_reg <= emit_idx_reg + 1'b1;
                    idx_reg <= idx_reg + 1'b1;
                end
                else if (!out_valid_q)
                begin
                    fetch_reg <= 1'b1;
                end
            end
            else
            begin
                state_reg <= state_next;
                idx_reg <= idx_next;
                emit_idx_reg <= '0;
                fetch_reg <= 1'b0;
                if (state_next == ST_RESULT && state_reg != ST_RESULT)
                begin
                    out_valid_q <= 1'b1;
                end
                else if (state_reg == ST_RESULT && !out_stall)
                begin
                    out_valid_q <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            item_reg <= in_data;
        end
        if (state_reg == ST_EMIT)
        begin
            if (fetch_reg && !out_valid_q)
            begin
                res_reg <= '{kind: KIND_RELEASED, out_handle: hnd_rd,
                             low_watermark: wm_cur, last: emit_last};
            end
        end
        else
        begin
            res_reg <= res_next;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (set_valid)
        begin
            valid_next[slot_reg] = 1'b1;
        end
        if (clr_valid)
        begin
            valid_next[adv_slot] = 1'b0;
        end
    end

    assign in_stall  = state_reg != ST_IDLE;
    assign out_valid = out_valid_q;
    assign out_data  = res_reg;

    // Assertions
    a_idle_no_out: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !out_valid_q)
        else $error("result shown while idle");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_q && out_stall |=> out_valid_q && $stable(res_reg))
        else $error("stalled result changed");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_q |-> in_stall)
        else $error("input taken with result pending");

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the chunk reassembly dedup window block. A behavioral
// predictor tracks watermarks and record slots, queues the expected results
// of each accepted transaction, and a checker compares every output
// transaction field by field. Directed cases come first, then a receiver hold,
// then random well-formed reassembly traffic mixed with noise and random idling.
// ----------------------------------------------------------------------------
module tb_top;
    import crdw_pkg::*;

    localparam int NORG  = 4;
    localparam int WIN   = 16;
    localparam int MAXC  = 8;
    localparam int NSLOT = NORG * WIN;
    localparam longint CYCLE_LIMIT = 400000;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_stall;
    out_item_t out_data;

    chunk_reassembly_dedup_window_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // Predictor state
    logic [31:0] wm_q [NORG];
    logic        sv_q [NSLOT];
    logic [31:0] sseq_q [NSLOT];
    logic [15:0] sep_q [NSLOT];
    logic        sdone_q [NSLOT];
    logic        sfin_q [NSLOT];
    logic [7:0]  sexp_q [NSLOT];
    logic [7:0]  smap_q [NSLOT];
    logic [15:0] shnd_q [NSLOT][MAXC];
    int          scnt_q [NSLOT];

    out_item_t expected_results [$];
    int        fail_count;
    longint    cycle_count;
    bit        quiet_phase;
    bit        hold_rx;
    int        hold_len;

    // Clock
    initial clk = 1'b0;
    always #4 clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH: %s", msg);
        fail_count++;
    endtask

    function automatic int slot_index(input logic [1:0] o, input logic [31:0] s);
        return int'(o) * WIN + int'(s % WIN);
    endfunction

    function automatic bit slot_holds(input int s, input logic [31:0] seq);
        return sv_q[s] && sseq_q[s] == seq;
    endfunction

    task automatic push_result(input kind_t k, input logic [15:0] h,
                               input logic [31:0] w, input logic l);
        out_item_t r;
        r.kind = k;
        r.out_handle = h;
        r.low_watermark = w;
        r.last = l;
        expected_results.insert(expected_results.size(), r);
    endtask

    task automatic predictor_reset();
        for (int i = 0; i < NORG; i++) wm_q[i] = '0;
        for (int i = 0; i < NSLOT; i++)
        begin
            sv_q[i] = 0; sseq_q[i] = '0; sep_q[i] = '0; sdone_q[i] = 0;
            sfin_q[i] = 0; sexp_q[i] = '0; smap_q[i] = '0; scnt_q[i] = 0;
        end
    endtask

    // Compute the expected results of one accepted transaction
    task automatic predict_reassembly(input in_item_t it);
        int s;
        logic [31:0] w;
        logic [31:0] nxt;
        int ns;
        logic [7:0] bitm;
        w = wm_q[it.origin];
        if ({32'd0, it.seq_num} > {32'd0, w} + WIN)
        begin
            push_result(KIND_OUT_WIN, '0, w, 1'b1);
            return;
        end
        s = slot_index(it.origin, it.seq_num);
        if (it.op == OP_FINALIZE)
        begin
            if (it.seq_num <= w || !slot_holds(s, it.seq_num))
            begin
                push_result(KIND_UNKNOWN, '0, w, 1'b1);
                return;
            end
            sfin_q[s] = 1;
            scnt_q[s] = 0;
            // advance over consecutive finalized records
            for (int i = 0; i < WIN; i++)
            begin
                nxt = wm_q[it.origin] + 1;
                ns = slot_index(it.origin, nxt);
                if (!slot_holds(ns, nxt) || !sfin_q[ns]) break;
                sv_q[ns] = 0;
                wm_q[it.origin] = nxt;
            end
            push_result(KIND_FINAL, '0, wm_q[it.origin], 1'b1);
            return;
        end
        if (it.seq_num <= w)
        begin
            push_result(KIND_DROPPED, '0, w, 1'b1);
            return;
        end
        if (it.chunk_num == 0 || it.chunk_num > MAXC)
        begin
            push_result(KIND_BAD, '0, w, 1'b1);
            return;
        end
        if (!slot_holds(s, it.seq_num))
        begin
            sv_q[s] = 1; sseq_q[s] = it.seq_num; sep_q[s] = it.epoch;
            sdone_q[s] = 0; sfin_q[s] = 0; sexp_q[s] = '0; smap_q[s] = '0;
            scnt_q[s] = 0;
        end
        if (sdone_q[s])
        begin
            push_result(KIND_DROPPED, '0, w, 1'b1);
            return;
        end
        if (sep_q[s] != it.epoch)
        begin
            scnt_q[s] = 0; sexp_q[s] = '0; sep_q[s] = it.epoch; smap_q[s] = '0;
        end
        if (it.is_last) sexp_q[s] = it.chunk_num;
        bitm = 8'd1 << (it.chunk_num - 1);
        if ((smap_q[s] & bitm) == 0 && scnt_q[s] < MAXC)
        begin
            smap_q[s] |= bitm;
            shnd_q[s][scnt_q[s]] = it.handle;
            scnt_q[s]++;
        end
        if (sexp_q[s] != 0 && scnt_q[s] == int'(sexp_q[s]))
        begin
            sdone_q[s] = 1;
            for (int k = 0; k < scnt_q[s]; k++)
                push_result(KIND_RELEASED, shnd_q[s][k], w, k == scnt_q[s] - 1);
            return;
        end
        push_result(KIND_PENDING, '0, w, 1'b1);
    endtask

    // Send one transaction, with an optional random gap before it; valid
    // stays high until the next send or a drain replaces or drops it
    task automatic send_item(input in_item_t it);
        if (!quiet_phase && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_reassembly(it);
    endtask

    function automatic in_item_t make_chunk(input logic [1:0] o, input logic [31:0] s,
                                            input logic [15:0] e, input logic [7:0] c,
                                            input logic l, input logic [15:0] h);
        in_item_t it;
        it.op = OP_CHUNK; it.origin = o; it.seq_num = s; it.epoch = e;
        it.chunk_num = c; it.is_last = l; it.handle = h;
        return it;
    endfunction

    function automatic in_item_t make_final(input logic [1:0] o, input logic [31:0] s);
        in_item_t it;
        it = make_chunk(o, s, 16'($urandom), 8'($urandom), 1'($urandom), 16'($urandom));
        it.op = OP_FINALIZE;
        return it;
    endfunction

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // Directed: extremes, special cases, both ops
    task automatic test_directed();
        send_item(make_chunk(2'd0, 32'd0, 16'd1, 8'd1, 1'b1, 16'hFFFF));     // at watermark
        send_item(make_chunk(2'd0, 32'hFFFF_FFFF, 16'd0, 8'd1, 1'b0, 16'd0)); // beyond
        send_item(make_final(2'd1, 32'hFFFF_FFFF));
        send_item(make_final(2'd1, 32'd0));                                    // unknown
        send_item(make_final(2'd1, 32'd3));                                    // unknown
        send_item(make_chunk(2'd0, 32'd1, 16'd5, 8'd0, 1'b0, 16'd1));         // bad zero
        send_item(make_chunk(2'd0, 32'd1, 16'd5, 8'd255, 1'b1, 16'd1));       // bad high
        send_item(make_chunk(2'd0, 32'd1, 16'd5, 8'd9, 1'b0, 16'd1));
        send_item(make_chunk(2'd0, 32'd1, 16'd5, 8'd2, 1'b1, 16'h1234));      // pending
        send_item(make_chunk(2'd0, 32'd1, 16'd5, 8'd2, 1'b1, 16'h4321));      // duplicate
        send_item(make_chunk(2'd0, 32'd1, 16'd5, 8'd1, 1'b0, 16'hAAAA));      // complete
        send_item(make_chunk(2'd0, 32'd1, 16'd5, 8'd3, 1'b0, 16'h5555));      // done drop
        send_item(make_chunk(2'd0, 32'd2, 16'd7, 8'd8, 1'b1, 16'h0001));
        send_item(make_chunk(2'd0, 32'd2, 16'hFFFF, 8'd1, 1'b1, 16'h0002));   // new epoch
        send_item(make_final(2'd0, 32'd2));                                    // no advance
        send_item(make_final(2'd0, 32'd1));                                    // advance by 2
        send_item(make_chunk(2'd3, 32'd16, 16'd0, 8'd1, 1'b0, 16'd3));        // window edge
        send_item(make_final(2'd3, 32'd16));                                   // unfinished fin
        send_item(make_chunk(2'd3, 32'd16, 16'd0, 8'd1, 1'b1, 16'd4));        // stays pending
        send_item(make_chunk(2'd3, 32'd17, 16'd0, 8'd1, 1'b1, 16'd5));        // beyond
        send_item(make_chunk(2'd2, 32'd4, 16'd9, 8'd1, 1'b0, 16'd6));
        send_item(make_chunk(2'd2, 32'd4, 16'd9, 8'd1, 1'b1, 16'd7));
        wait_drained();
    endtask

    // Random: full records in random chunk order, then mostly a finalize, mixed with noise
    task automatic test_random_reassembly(input int n_items);
        int sent;
        logic [1:0] o;
        logic [31:0] sq;
        int nc;
        logic [7:0] order [MAXC];
        logic [7:0] tmp;
        int j;
        logic [15:0] ep;
        sent = 0;
        while (sent < n_items)
        begin
            o = 2'($urandom);
            if ($urandom_range(0, 4) == 0)
            begin
                // noise: random fields near the window
                in_item_t it;
                it = make_chunk(o, wm_q[o] + $urandom_range(0, WIN + 2), 16'($urandom),
                                8'($urandom_range(0, 10)), 1'($urandom), 16'($urandom));
                if ($urandom_range(0, 7) == 0) it.seq_num = $urandom;
                it.op = 1'($urandom);
                send_item(it);
                sent++;
                continue;
            end
            sq = wm_q[o] + $urandom_range(1, 4);
            ep = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'd1;
            nc = ($urandom_range(0, 5) == 0) ? MAXC : $urandom_range(1, 3);
            for (int i = 0; i < MAXC; i++) order[i] = 8'(i + 1);
            for (int i = nc - 1; i > 0; i--)
            begin
                j = $urandom_range(0, i);
                tmp = order[i]; order[i] = order[j]; order[j] = tmp;
            end
            for (int i = 0; i < nc; i++)
            begin
                send_item(make_chunk(o, sq, ep, order[i], order[i] == nc, 16'($urandom)));
                sent++;
                if ($urandom_range(0, 9) == 0)
                begin
                    send_item(make_chunk(o, sq, ep, order[i], 1'b0, 16'($urandom)));
                    sent++;
                end
            end
            if ($urandom_range(0, 3) != 0)
            begin
                send_item(make_final(o, sq));
                sent++;
            end
        end
    endtask

    // Receiver holds off for a long stretch while the chunks of one record queue behind it
    task automatic test_backpressure();
        hold_len = 300;
        hold_rx = 1'b1;
        for (int i = 1; i <= 6; i++)
            send_item(make_chunk(2'd1, wm_q[1] + 1, 16'd2, 8'(i), i == 6, 16'($urandom)));
        wait_drained();
    endtask

    // Output stall generation
    initial
    begin
        int burst;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_rx)
            begin
                out_stall <= 1'b1;
                repeat (hold_len) @(posedge clk);
                hold_rx = 1'b0;
                out_stall <= 1'b0;
            end
            else if (!quiet_phase && $urandom_range(0, 5) == 0)
            begin
                burst = $urandom_range(1, 10);
                out_stall <= 1'b1;
                repeat (burst) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Check each output transaction against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            out_item_t e;
            if (expected_results.size() == 0)
                report_mismatch($sformatf("unexpected result %p", out_data));
            else
            begin
                e = expected_results.pop_front();
                if (out_data.kind !== e.kind)
                    report_mismatch($sformatf("kind %0d exp %0d", out_data.kind, e.kind));
                if (out_data.out_handle !== e.out_handle)
                    report_mismatch($sformatf("handle %h exp %h",
                                              out_data.out_handle, e.out_handle));
                if (out_data.low_watermark !== e.low_watermark)
                    report_mismatch($sformatf("watermark %0d exp %0d",
                                              out_data.low_watermark, e.low_watermark));
                if (out_data.last !== e.last)
                    report_mismatch($sformatf("last %b exp %b", out_data.last, e.last));
            end
        end
    end

    // Timeout
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("chunk_reassembly_dedup_window_top verification failed");
            $finish;
        end
    end

    initial
    begin
        fail_count  = 0;
        cycle_count = 0;
        quiet_phase = 1'b0;
        hold_rx     = 1'b0;
        hold_len    = 0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        predictor_reset();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_random_reassembly(240);
        quiet_phase = 1'b1;
        test_random_reassembly(60);
        wait_drained();
        if (expected_results.size() != 0)
            report_mismatch("expected results left over");
        if (fail_count == 0)
            $display("chunk_reassembly_dedup_window_top verification clean");
        else
            $display("chunk_reassembly_dedup_window_top verification failed");
        $finish;
    end

endmodule
